[rtl/lcr_pkg.sv]
// ----------------------------------------------------------------------------
// lcr_pkg
// shared types and constants of the line command recognizer
// ----------------------------------------------------------------------------
package lcr_pkg;

	localparam int LINE_LEN = 64;
	localparam int IDX_W = $clog2(LINE_LEN);
	localparam int CNT_W = $clog2(LINE_LEN + 1);

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_SYNTAX   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN  = 3'd3;
	localparam logic [2:0] ST_BADARG   = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;

	localparam logic [2:0] CMD_HELP     = 3'd0;
	localparam logic [2:0] CMD_BAUD_SET = 3'd6;

	localparam logic [31:0] ARG_NONE = 32'hFFFF_FFFF;
	localparam int KEY_COUNT = 6;
	localparam int KEY_MAX = 10;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RECV,
		S_SCAN,
		S_DONE,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start_line;
		logic store_byte;
		logic scan_start;
		logic scan_step;
		logic load_syntax;
		logic load_overflow;
		logic load_final;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic scan_last;
	} stat_t;

	function automatic logic bad_start(input logic [7:0] b);
		return b == 8'h00 || b == 8'h0D || b == 8'h0A || b == 8'h23 ||
		       b == 8'h2D || b == 8'h20 || b == 8'h09;
	endfunction

	// character i of key k, zero past its end
	function automatic logic [7:0] key_char(input int k, input int i);
		logic [8*KEY_MAX-1:0] s;
		int n;
		case (k)
			0: begin s = 80'("HELP"); n = 4; end
			1: begin s = 80'("LED ON"); n = 6; end
			2: begin s = 80'("LED OFF"); n = 7; end
			3: begin s = 80'("LED TOGGLE"); n = 10; end
			4: begin s = 80'("STATUS"); n = 6; end
			default: begin s = 80'("BAUD?"); n = 5; end
		endcase
		return (i >= 0 && i < n) ? s[8*(n-1-i) +: 8] : 8'h00;
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
	endfunction

endpackage

[rtl/lcr_ram.sv]
// ----------------------------------------------------------------------------
// lcr_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module lcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[rtl/lcr_datapath.sv]
// ----------------------------------------------------------------------------
// lcr_datapath
// line store, fill count and a byte-serial line scanner
// ----------------------------------------------------------------------------
module lcr_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  lcr_pkg::cmd_t cmd,
	input  logic [7:0]    rx_byte,
	output lcr_pkg::stat_t stat,
	output logic [2:0]    status,
	output logic [2:0]    command,
	output logic [31:0]   argument
);
	import lcr_pkg::*;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] end_q;
	logic [CNT_W-1:0] pos_q;   // address presented to ram
	logic [CNT_W-1:0] idx_q;   // index of byte in rdata
	logic             done_q;  // zero or end seen
	logic [CNT_W-1:0] len_q;
	logic [KEY_COUNT-1:0] key_ok_q;
	logic             baud_ok_q;
	logic             eq_seen_q;
	logic [CNT_W-1:0] eq_q;
	// argument parse: 0 lead blanks, 1 after sign, 2 digits, 3 bad
	logic [1:0]       ph_q;
	logic             neg_q;
	logic [31:0]      mag_q;
	logic [34:0]      mag_next;
	logic [7:0]       rd;
	logic             we;
	logic [IDX_W-1:0] addr;
	logic [7:0]       c;

	assign we = cmd.start_line || cmd.store_byte;
	assign addr = (cmd.start_line || cmd.scan_start) ? '0
	            : (we ? fill_q[IDX_W-1:0] : pos_q[IDX_W-1:0]);

	lcr_ram #(.WIDTH(8), .DEPTH(LINE_LEN)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(rx_byte), .rdata(rd)
	);

	assign c = upcase(rd);
	assign stat.full = fill_q >= CNT_W'(LINE_LEN);
	assign stat.scan_last = done_q;
	assign mag_next = {mag_q, 3'b0} + {2'b0, mag_q, 1'b0} + 35'(c - 8'h30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.start_line) begin
			fill_q <= CNT_W'(1);
		end else if (cmd.store_byte) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			end_q <= (fill_q >= CNT_W'(LINE_LEN)) ? CNT_W'(LINE_LEN - 1) : fill_q;
			pos_q <= CNT_W'(1);
			idx_q <= '0;
			done_q <= 1'b0;
			len_q <= '0;
			key_ok_q <= '1;
			baud_ok_q <= 1'b1;
			eq_seen_q <= 1'b0;
			ph_q <= 2'd0;
			neg_q <= 1'b0;
			mag_q <= '0;
		end else if (cmd.scan_step && !done_q) begin
			pos_q <= pos_q + 1'b1;
			idx_q <= idx_q + 1'b1;
			if (idx_q == end_q || rd == 8'h00) begin
				done_q <= 1'b1;
				len_q <= idx_q;
				for (int k = 0; k < KEY_COUNT; k++) begin
					if (key_char(k, int'(idx_q)) != 8'h00 || idx_q > CNT_W'(KEY_MAX)) begin
						key_ok_q[k] <= 1'b0;
					end
				end
			end else begin
				for (int k = 0; k < KEY_COUNT; k++) begin
					if (idx_q >= CNT_W'(KEY_MAX) || key_char(k, int'(idx_q)) != c) begin
						key_ok_q[k] <= 1'b0;
					end
				end
				if (idx_q < CNT_W'(5) && key_char(5, int'(idx_q[2:0])) != 8'h00 &&
				    idx_q != CNT_W'(4) && key_char(5, int'(idx_q[2:0])) != c) begin
					baud_ok_q <= 1'b0;
				end
				if (idx_q == CNT_W'(4) && c != 8'h3D) begin
					baud_ok_q <= 1'b0;
				end
				if (!eq_seen_q) begin
					if (c == 8'h3D) begin
						eq_seen_q <= 1'b1;
						eq_q <= idx_q;
					end
				end else begin
					unique case (ph_q)
						2'd0: begin
							if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C) begin
								ph_q <= 2'd0;
							end else if (c == 8'h2B || c == 8'h2D) begin
								neg_q <= c == 8'h2D;
								ph_q <= 2'd1;
							end else if (c >= 8'h30 && c <= 8'h39) begin
								mag_q <= 32'(c - 8'h30);
								ph_q <= 2'd2;
							end else begin
								ph_q <= 2'd3;
							end
						end
						2'd1, 2'd2: begin
							if (c >= 8'h30 && c <= 8'h39) begin
								mag_q <= (mag_next > 35'h8000_0000) ? 32'h8000_0000
								         : mag_next[31:0];
								ph_q <= 2'd2;
							end else begin
								ph_q <= 2'd3;
							end
						end
						default: ph_q <= 2'd3;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.load_syntax) begin
			status <= ST_SYNTAX; command <= CMD_HELP; argument <= ARG_NONE;
		end else if (cmd.load_overflow) begin
			status <= ST_OVERFLOW; command <= CMD_HELP; argument <= ARG_NONE;
		end else if (cmd.load_final) begin
			command <= CMD_HELP;
			argument <= ARG_NONE;
			if (len_q == '0) begin
				status <= ST_EMPTY;
			end else if (eq_seen_q) begin
				if (ph_q != 2'd2) begin
					status <= ST_BADARG;
				end else if (eq_q == CNT_W'(4) && baud_ok_q) begin
					status <= ST_OK;
					command <= CMD_BAUD_SET;
					argument <= neg_q ? 32'(0) - mag_q
					          : (mag_q[31] ? 32'h7FFF_FFFF : mag_q);
				end else begin
					status <= ST_UNKNOWN;
				end
			end else begin
				status <= ST_UNKNOWN;
				for (int k = 0; k < KEY_COUNT; k++) begin
					if (key_ok_q[k]) begin
						status <= ST_OK;
						command <= 3'(k);
					end
				end
			end
		end
	end
endmodule

[rtl/lcr_ctrl.sv]
// ----------------------------------------------------------------------------
// lcr_ctrl
// controller: receive, scan and result handshake
// ----------------------------------------------------------------------------
module lcr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     in_byte,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  lcr_pkg::stat_t stat,
	output lcr_pkg::cmd_t  cmd
);
	import lcr_pkg::*;

	state_t state_q, state_d;
	logic   acc;

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					if (bad_start(in_byte)) begin
						cmd.load_syntax = 1'b1;
						state_d = S_OUT;
					end else begin
						cmd.start_line = 1'b1;
						state_d = S_RECV;
					end
				end
			end
			S_RECV: begin
				in_ready = 1'b1;
				if (acc) begin
					if (in_byte == 8'h0D || in_byte == 8'h0A) begin
						cmd.scan_start = 1'b1;
						state_d = S_SCAN;
					end else if (stat.full) begin
						cmd.load_overflow = 1'b1;
						state_d = S_OUT;
					end else begin
						cmd.store_byte = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.load_final = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

[rtl/line_command_recognizer.sv]
// ----------------------------------------------------------------------------
// line_command_recognizer
// collects received bytes into a line and recognizes fixed text commands
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one received byte per transaction (tdata = rx_byte)
//   m_axis carries one result per finished line or error
//   bytes of a line are stored in a 64-entry single-port ram, one per cycle
//   a bad first byte or a byte past the store gives a result in the next cycle
//   a cr or lf ends the line; the controller then reads the store once,
//   one byte per cycle, up to the first zero byte and at most 63 bytes,
//   and then offers its result
//   no byte is taken while a line is scanned or a result is waiting;
//   a stalled receiver holds m_axis_tdata steady until taken
//   reset clears the controller and fill count; the ram needs no clearing
//   since only written entries are ever read
// ----------------------------------------------------------------------------
module line_command_recognizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // status[2:0], command[5:3], argument[37:6], zeros
);
	import lcr_pkg::*;

	cmd_t        cmd;
	stat_t       stat;
	logic [2:0]  status;
	logic [2:0]  command;
	logic [31:0] argument;

	lcr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	lcr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rx_byte(s_axis_tdata),
		.stat(stat), .status(status), .command(command), .argument(argument)
	);

	assign m_axis_tdata = {2'b00, argument, command, status};
endmodule

[rtl/lcr_checker.sv]
// ----------------------------------------------------------------------------
// lcr_checker
// port-level checks of the line command recognizer
// ----------------------------------------------------------------------------
module lcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	// never take a byte while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	// status code in range
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5) else $error("bad status");
	// non-ok results carry no command
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[5:3] == 3'd0)
		else $error("command on error");
endmodule

bind line_command_recognizer lcr_checker u_lcr_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

[bench/tb_line_command_recognizer.sv]
// ----------------------------------------------------------------------------
// tb_line_command_recognizer
// checks the line command recognizer against a behavioral predictor: directed
// table of lines, then random well-formed and broken lines with random idling
// ----------------------------------------------------------------------------
module tb_line_command_recognizer;
	timeunit 1ns;
	timeprecision 1ps;

	import lcr_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  command;
		logic [31:0] argument;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;    // rx_byte[7:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;            // status[2:0], command[5:3], argument[37:6]

	line_command_recognizer u_dut (.*);

	always #2 clk = ~clk;

	// predictor state
	logic [7:0] line_buf [LINE_LEN];
	int         line_fill;
	bit         collecting;

	verdict_t   pending_verdicts[$];
	int         error_count;
	int         cycle_count;
	int         stall_left = 0;
	bit         calm;           // no idling in the last part

	task automatic report(input string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// evaluates a finished line
	function automatic verdict_t judge_line();
		verdict_t v;
		logic [7:0] t [LINE_LEN];
		int n, eq, p, digits, k, i;
		longint mag;
		bit neg, hit;
		string key;
		v = '{ST_UNKNOWN, CMD_HELP, ARG_NONE};
		n = 0;
		eq = -1;
		digits = 0;
		mag = 0;
		neg = 0;
		for (i = 0; i < LINE_LEN; i++)
			t[i] = (i < line_fill && i < LINE_LEN - 1) ? line_buf[i] : 8'h00;
		while (n < LINE_LEN && t[n] != 8'h00)
			n++;
		if (n == 0) begin
			v.status = ST_EMPTY;
			return v;
		end
		for (i = 0; i < n; i++) begin
			if (t[i] >= "a" && t[i] <= "z")
				t[i] = t[i] - 8'h20;
			if (eq < 0 && t[i] == "=")
				eq = i;
		end
		if (eq >= 0) begin
			p = eq + 1;
			if (p >= n) begin
				v.status = ST_BADARG;
				return v;
			end
			while (p < n && (t[p] == 8'h20 || t[p] == 8'h09 || t[p] == 8'h0B ||
			                 t[p] == 8'h0C))
				p++;
			if (p < n && (t[p] == "+" || t[p] == "-")) begin
				neg = t[p] == "-";
				p++;
			end
			while (p < n && is_digit(t[p])) begin
				mag = mag * 10 + (t[p] - "0");
				if (mag > 64'h8000_0000)
					mag = 64'h8000_0000;
				digits++;
				p++;
			end
			if (digits == 0 || p != n) begin
				v.status = ST_BADARG;
				return v;
			end
			if (eq == 4 && t[0] == "B" && t[1] == "A" && t[2] == "U" && t[3] == "D") begin
				v.status = ST_OK;
				v.command = CMD_BAUD_SET;
				if (neg)
					v.argument = 32'(-mag);
				else
					v.argument = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
			end
			return v;
		end
		for (k = 0; k < KEY_COUNT; k++) begin
			case (k)
				0: key = "HELP";
				1: key = "LED ON";
				2: key = "LED OFF";
				3: key = "LED TOGGLE";
				4: key = "STATUS";
				default: key = "BAUD?";
			endcase
			hit = key.len() == n;
			for (i = 0; hit && i < n; i++)
				if (t[i] != key[i])
					hit = 0;
			if (hit) begin
				v.status = ST_OK;
				v.command = 3'(k);
				return v;
			end
		end
		return v;
	endfunction

	// advances the predictor by one byte; returns 1 with a verdict when one is due
	function automatic bit predict_byte(input logic [7:0] b, output verdict_t v);
		bit due;
		due = 1'b0;
		v = '{ST_SYNTAX, CMD_HELP, ARG_NONE};
		if (!collecting) begin
			if (bad_start(b))
				due = 1'b1;
			else begin
				line_buf[0] = b;
				line_fill = 1;
				collecting = 1'b1;
			end
		end else if (b == 8'h0D || b == 8'h0A) begin
			v = judge_line();
			due = 1'b1;
		end else if (line_fill >= LINE_LEN) begin
			v.status = ST_OVERFLOW;
			due = 1'b1;
		end else begin
			line_buf[line_fill] = b;
			line_fill++;
		end
		if (due) begin
			collecting = 1'b0;
			line_fill = 0;
		end
		return due;
	endfunction

	// sends one byte; checks a typed-in expectation when given
	task automatic send_byte(input logic [7:0] b, input bit typed = 0,
	                         input verdict_t typed_v = '0);
		verdict_t v;
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		if (predict_byte(b, v)) begin
			if (typed && v != typed_v)
				report($sformatf("typed expectation disagrees for byte %h", b));
			pending_verdicts.push_back(typed ? typed_v : v);
		end
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	// receiver with random stall bursts
	always @(posedge clk) begin
		verdict_t got, want;
		cycle_count <= cycle_count + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[2:0];
			got.command = m_axis_tdata[5:3];
			got.argument = m_axis_tdata[37:6];
			if (pending_verdicts.size() == 0)
				report($sformatf("unexpected result %h", got));
			else begin
				want = pending_verdicts.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d want %0d", got.status, want.status));
				if (got.command !== want.command)
					report($sformatf("command %0d want %0d", got.command, want.command));
				if (got.argument !== want.argument)
					report($sformatf("argument %h want %h", got.argument, want.argument));
			end
		end
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end

	// directed lines: text, optional typed expectation
	typedef struct {
		string    text;
		bit       typed;
		verdict_t want;
	} row_t;

	row_t plan[$];

	task automatic random_line();
		string s;
		int n, r, i;
		r = $urandom_range(0, 9);
		case (r)
			0: s = "help";
			1: s = "Led On";
			2: s = "LED off";
			3: s = "led toggle";
			4: s = "status";
			5: s = "baud?";
			6, 7: s = $sformatf("BaUd=%s%0d", ($urandom_range(0, 1) ? "-" : "+"),
			                   $urandom());
			8: s = $sformatf("xy=%0d", $urandom_range(0, 999));
			default: begin
				s = "";
				n = $urandom_range(1, 70);
				for (i = 0; i < n; i++)
					s = {s, string'(8'($urandom_range(0, 255)))};
			end
		endcase
		if (r != 9 && $urandom_range(0, 7) == 0)
			s = {s, string'(8'($urandom_range(0, 255)))};
		send_text(s);
		if (!collecting && s.len() > 0)
			return;
		send_byte($urandom_range(0, 1) ? 8'h0D : 8'h0A);
	endtask

	initial begin
		string big;
		line_fill = 0;
		collecting = 0;
		error_count = 0;
		cycle_count = 0;
		calm = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		big = "";
		for (int i = 0; i < LINE_LEN; i++)
			big = {big, "A"};
		plan.push_back('{"HELP\r", 1, '{ST_OK, 3'd0, ARG_NONE}});
		plan.push_back('{"led on\n", 1, '{ST_OK, 3'd1, ARG_NONE}});
		plan.push_back('{"LED OFF\r", 1, '{ST_OK, 3'd2, ARG_NONE}});
		plan.push_back('{"Led Toggle\r", 1, '{ST_OK, 3'd3, ARG_NONE}});
		plan.push_back('{"STATUS\r", 1, '{ST_OK, 3'd4, ARG_NONE}});
		plan.push_back('{"BAUD?\r\n", 0, '0});
		plan.push_back('{"BAUD=115200\r", 1, '{ST_OK, CMD_BAUD_SET, 32'd115200}});
		plan.push_back('{"baud= -99999999999\r", 1, '{ST_OK, CMD_BAUD_SET, 32'h8000_0000}});
		plan.push_back('{"BAUD=+99999999999\r", 1, '{ST_OK, CMD_BAUD_SET, 32'h7FFF_FFFF}});
		plan.push_back('{"BAUD=-1\r", 0, '0});
		plan.push_back('{"BAUD=\r", 1, '{ST_BADARG, CMD_HELP, ARG_NONE}});
		plan.push_back('{"BAUD=12x\r", 1, '{ST_BADARG, CMD_HELP, ARG_NONE}});
		plan.push_back('{"X=5\r", 1, '{ST_UNKNOWN, CMD_HELP, ARG_NONE}});
		plan.push_back('{"#", 1, '{ST_SYNTAX, CMD_HELP, ARG_NONE}});
		plan.push_back('{"-", 0, '0});
		plan.push_back('{" \t", 0, '0});
		plan.push_back('{{big, "\r"}, 0, '0});
		plan.push_back('{{big, "B"}, 1, '{ST_OVERFLOW, CMD_HELP, ARG_NONE}});
		plan.push_back('{{"HELP", 8'hFF, "\r"}, 0, '0});

		foreach (plan[r]) begin
			for (int i = 0; i < plan[r].text.len(); i++)
				send_byte(plan[r].text[i], plan[r].typed && i == plan[r].text.len() - 1,
				          plan[r].want);
		end
		// zero inside a line cuts it before matching
		send_text("HE");
		send_byte(8'h00);
		send_text("LP");
		send_byte(8'h0D, 1, '{ST_UNKNOWN, CMD_HELP, ARG_NONE});
		// bare zero, cr, lf as first byte
		send_byte(8'h00, 1, '{ST_SYNTAX, CMD_HELP, ARG_NONE});
		send_byte(8'h0D);
		send_byte(8'h0A);

		// random lines, 75 in all
		for (int n = 0; n < 75; n++) begin
			if (n == 62)
				calm = 1;
			random_line();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
